[hw/rtl/scca_pkg.sv]
// ---------------------------------------------------------------------------
// scca_pkg: shared types and constants for the cycle counter accumulator
// Request and response payloads, request codes, poison patterns and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scca_pkg;

  localparam int CORE_IDX_W = 3;
  localparam int DATA_W     = 64;

  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_SUSPEND = 2'd1;
  localparam logic [1:0] REQ_OFFLINE = 2'd2;
  localparam logic [1:0] REQ_ONLINE  = 2'd3;

  localparam logic [63:0] POISON_FULL = 64'hdeadbeafdeadbeaf;
  localparam logic [31:0] POISON_HALF = 32'hdeadbeaf;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [CORE_IDX_W-1:0] core_index;
    logic                  event_index;
    logic [DATA_W-1:0]     raw_reading;
    logic [DATA_W-1:0]     core_snapshot;
    logic [DATA_W-1:0]     const_snapshot;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] accumulated_total;
    logic [DATA_W-1:0] accepted_value;
    logic              backwards_warning;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic exec;    // sample in progress, address from held request
    logic commit;  // write back and load the response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic is_sample;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/scca_ram.sv]
// ---------------------------------------------------------------------------
// scca_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/scca_ctrl.sv]
// ---------------------------------------------------------------------------
// scca_ctrl: request sequencer
// Takes requests, holds the input off while a sample read is computed and
// waits for room in the response register before committing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scca_ctrl import scca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_range && sts.is_sample) begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        req_stall = 1'b1;
        cmd.exec  = 1'b1;
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/scca_dpath.sv]
// ---------------------------------------------------------------------------
// scca_dpath: counter store and update datapath
// Total/previous and snapshot RAMs with per-entry valid bits, offline marks,
// reading check, substitution, clamp and accumulate, response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scca_dpath import scca_pkg::*; #(
  parameter int NUM_CORES = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  input  wire logic rsp_stall,
  output logic      rsp_valid,
  output res_t      rsp
);

  localparam int SLOTS = NUM_CORES * 2;
  localparam int CW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int CMPW  = ((CW > CORE_IDX_W) ? CW : CORE_IDX_W) + 1;

  // request decode
  logic [CMPW-1:0] core_wide;
  logic [CW-1:0]   in_core;
  logic [CW:0]     in_slot_full;
  logic [SW-1:0]   in_slot;
  logic            snap_req;

  assign core_wide    = CMPW'(req.core_index);
  assign in_core      = core_wide[CW-1:0];
  assign in_slot_full = {in_core, req.event_index};
  assign in_slot      = in_slot_full[SW-1:0];

  assign sts.in_range  = core_wide < CMPW'(NUM_CORES);
  assign sts.is_sample = (req.req_type == REQ_SAMPLE);
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    case (req.req_type) inside
      REQ_SUSPEND, REQ_OFFLINE: snap_req = 1'b1;
      default:                  snap_req = 1'b0;
    endcase
  end

  // held sample request
  logic [CW-1:0]     core_q;
  logic              ev_q;
  logic [DATA_W-1:0] raw_q;
  logic [CW:0]       slot_full_q;
  logic [SW-1:0]     slot_q;

  assign slot_full_q = {core_q, ev_q};
  assign slot_q      = slot_full_q[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      core_q <= in_core;
      ev_q   <= req.event_index;
      raw_q  <= req.raw_reading;
    end
  end

  // offline marks and valid bits
  logic [NUM_CORES-1:0] offline;
  logic [NUM_CORES-1:0] snap_vld;
  logic [SLOTS-1:0]     tp_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      offline  <= '0;
      snap_vld <= '0;
      tp_vld   <= '0;
    end else begin
      if (cmd.accept && sts.in_range) begin
        if (req.req_type == REQ_ONLINE) begin
          offline[in_core] <= 1'b0;
        end else if (req.req_type == REQ_OFFLINE) begin
          offline[in_core] <= 1'b1;
        end
        if (snap_req) begin
          snap_vld[in_core] <= 1'b1;
        end
      end
      if (cmd.commit) begin
        tp_vld[slot_q] <= 1'b1;
      end
    end
  end

  // memories: snapshot row = {const, core}; total/prev row = {total, prev}
  logic [2*DATA_W-1:0] snap_rd;
  logic [2*DATA_W-1:0] tp_rd;
  logic [2*DATA_W-1:0] tp_wd;
  logic [CW-1:0]       snap_ra;
  logic [SW-1:0]       tp_ra;

  assign snap_ra = cmd.exec ? core_q : in_core;
  assign tp_ra   = cmd.exec ? slot_q : in_slot;

  scca_ram #(.WIDTH(2 * DATA_W), .DEPTH(NUM_CORES)) u_snap_ram (
    .clk   (clk),
    .we    (cmd.accept && sts.in_range && snap_req),
    .waddr (in_core),
    .wdata ({req.const_snapshot, req.core_snapshot}),
    .raddr (snap_ra),
    .rdata (snap_rd)
  );

  scca_ram #(.WIDTH(2 * DATA_W), .DEPTH(SLOTS)) u_tp_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (slot_q),
    .wdata (tp_wd),
    .raddr (tp_ra),
    .rdata (tp_rd)
  );

  // sample update
  logic [DATA_W-1:0] total;
  logic [DATA_W-1:0] prev;
  logic [DATA_W-1:0] snap;
  logic [DATA_W-1:0] v_sub;
  logic [DATA_W-1:0] v_acc;
  logic [DATA_W-1:0] total_new;
  logic              raw_bad;
  logic              below;
  logic              warn;

  always_comb begin
    total = tp_vld[slot_q] ? tp_rd[2*DATA_W-1:DATA_W] : '0;
    prev  = tp_vld[slot_q] ? tp_rd[DATA_W-1:0] : '0;
    if (!snap_vld[core_q]) begin
      snap = '0;
    end else if (ev_q) begin
      snap = snap_rd[2*DATA_W-1:DATA_W];
    end else begin
      snap = snap_rd[DATA_W-1:0];
    end
    raw_bad = (raw_q == '0) || (raw_q == POISON_FULL) ||
              (raw_q[63:32] == POISON_HALF) || (raw_q[31:0] == POISON_HALF);
    v_sub     = (raw_bad || offline[core_q]) ? snap : raw_q;
    below     = v_sub < prev;
    warn      = below && (v_sub != snap);
    v_acc     = below ? prev : v_sub;
    total_new = total + (v_acc - prev);
    tp_wd     = {total_new, v_acc};
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.accumulated_total <= total_new;
      rsp.accepted_value    <= v_acc;
      rsp.backwards_warning <= warn;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sanitized_cycle_counter_accumulator.sv]
// ---------------------------------------------------------------------------
// sanitized_cycle_counter_accumulator: per-core monotonic cycle totals
// Keeps a 64-bit running total per core and counter from raw samples.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req) carries sample reads,
//   snapshots, offline and online requests. Response channel
//   (rsp_valid/rsp_stall/rsp) returns one response per in-range sample read;
//   other requests and out-of-range cores return nothing.
//   Snapshot, offline and online requests never stall the request side. An
//   in-range sample read does: the store RAMs have a registered read port,
//   so the update runs in the cycle after the request, while no new request
//   is taken, and the response register is loaded when the update commits.
//   A finished response sits in an output register; the next request is
//   taken while it waits. A new sample waits in its update cycle (request
//   side stalled) only while the previous response is still held.
//   Reset clears the offline marks and per-entry valid bits, so all totals,
//   previous readings and snapshots read as zero; there is no clearing pass
//   and requests are taken in the first cycle after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sanitized_cycle_counter_accumulator import scca_pkg::*; #(
  parameter int NUM_CORES = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output res_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  scca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scca_dpath #(.NUM_CORES(NUM_CORES)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // an in-range sample read holds off the next request for its update cycle
  a_sample_holds: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.req_type == REQ_SAMPLE &&
     32'(req.core_index) < NUM_CORES) |=> req_stall)
    else $error("sample request not followed by update cycle");

  // a response only appears out of an update cycle
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without update cycle");

  // non-sample requests never produce a response
  a_no_rsp_other: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.req_type != REQ_SAMPLE) |=> !$rose(rsp_valid))
    else $error("response produced by non-sample request");

endmodule

`default_nettype wire
